// File: hw/rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, layout constants and decode helpers for the serial frame
// deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

	// frame layout
	localparam int BOOL_COUNT  = 8;
	localparam int BYTE_COUNT  = 4;
	localparam int SHORT_COUNT = 4;
	localparam int INT_COUNT   = 2;
	localparam int FLOAT_COUNT = 4;
	localparam int BOOL_BYTES  = BOOL_COUNT / 8 + 1;
	localparam int DATA_LEN    = BOOL_BYTES + BYTE_COUNT + SHORT_COUNT * 2 +
		INT_COUNT * 4 + FLOAT_COUNT * 4;
	// head, data, checksum, tail
	localparam int FRAME_LEN   = DATA_LEN + 3;
	localparam int TOTAL_FIELDS = BOOL_BYTES + BYTE_COUNT + SHORT_COUNT +
		INT_COUNT + FLOAT_COUNT;

	localparam int POS_W   = $clog2(FRAME_LEN + 1);
	localparam int MEM_DEPTH = 2 * DATA_LEN;
	localparam int ADDR_W  = $clog2(MEM_DEPTH);
	localparam int FCNT_W  = $clog2(TOTAL_FIELDS + 1);
	localparam int BYTE_W  = 8;
	localparam int VALUE_W = 32;

	localparam int JOBQ_DEPTH = 2;
	localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
	localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

	localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hA5;
	localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h5A;

	localparam logic [ADDR_W-1:0] BANK1_BASE = ADDR_W'(DATA_LEN);

	typedef enum logic {
		REG_HEAD = 1'b0,
		REG_TAIL = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		KIND_BOOL     = 3'd0,
		KIND_BYTE     = 3'd1,
		KIND_SHORT    = 3'd2,
		KIND_INT      = 3'd3,
		KIND_FLOAT    = 3'd4,
		KIND_BAD_SUM  = 3'd5,
		KIND_BAD_TAIL = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		JOB_DECODE   = 2'd0,
		JOB_BAD_SUM  = 2'd1,
		JOB_BAD_TAIL = 2'd2
	} job_op_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_READ = 2'd1,
		B_ACC  = 2'd2,
		B_EMIT = 2'd3
	} back_state_t;

	typedef struct packed {
		job_op_t           op;
		logic              bank;
		logic [BYTE_W-1:0] value;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_push_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic en;
		logic bank;
	} bank_rel_t;

	// number of fields of a kind; error kinds carry none
	function automatic logic [3:0] kind_count(input kind_t k);
		logic [3:0] r;
		case (k)
			KIND_BOOL:  r = 4'(BOOL_BYTES);
			KIND_BYTE:  r = 4'(BYTE_COUNT);
			KIND_SHORT: r = 4'(SHORT_COUNT);
			KIND_INT:   r = 4'(INT_COUNT);
			KIND_FLOAT: r = 4'(FLOAT_COUNT);
			default:    r = 4'd0;
		endcase
		return r;
	endfunction

	// bytes per field of a kind
	function automatic logic [2:0] kind_bytes(input kind_t k);
		logic [2:0] r;
		case (k)
			KIND_SHORT:             r = 3'd2;
			KIND_INT, KIND_FLOAT:   r = 3'd4;
			default:                r = 3'd1;
		endcase
		return r;
	endfunction

	// next data kind in layout order that has fields
	function automatic kind_t next_kind(input kind_t k);
		kind_t r;
		logic  found;
		r = KIND_FLOAT;
		found = 1'b0;
		for (int j = 0; j < 5; j++) begin
			if (!found && (3'(j) > k) && (kind_count(kind_t'(3'(j))) != 4'd0)) begin
				r = kind_t'(3'(j));
				found = 1'b1;
			end
		end
		return r;
	endfunction

	// keep only the bits of a bool byte that carry bools
	function automatic logic [BYTE_W-1:0] bool_mask(input logic [3:0] idx);
		int lo;
		int bits;
		lo = 8 * int'(idx);
		bits = BOOL_COUNT - lo;
		if (BOOL_COUNT >= lo + 8)
			return 8'hFF;
		else if (BOOL_COUNT <= lo)
			return 8'h00;
		else
			return 8'((9'd1 << bits) - 9'd1);
	endfunction

endpackage

// File: hw/rtl/sfd_if.sv
// ----------------------------------------------------------------------------
// sfd_if
// Valid/ready channels of the deframer: received bytes in, decoded fields out.
// ----------------------------------------------------------------------------
interface sfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  field_kind;
	logic [3:0]  field_index;
	logic [31:0] field_value;
	logic        last_field;

	modport source (output valid, output field_kind, output field_index,
		output field_value, output last_field, input ready);
	modport sink (input valid, input field_kind, input field_index,
		input field_value, input last_field, output ready);
endinterface

// File: hw/rtl/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front
// Byte front end: head/tail detection, position count, running sum, frame
// byte writes into the double-buffered store and job issue at frame end.
// ----------------------------------------------------------------------------
module sfd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  sfd_pkg::reg_idx_t  cfg_index,
	input  logic [7:0]         cfg_data,
	sfd_in_if.sink             rx,
	input  logic               q_full,
	input  sfd_pkg::bank_rel_t rel,
	output sfd_pkg::job_push_t push,
	output sfd_pkg::mem_wr_t   mem_wr
);
	import sfd_pkg::*;

	logic [BYTE_W-1:0] head_q, tail_q;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0] chk_q, chk_d;
	logic              bank_q, bank_d;
	logic [1:0]        busy_q, busy_d;
	logic              accept;

	// a bank still being decoded must not be overwritten
	assign rx.ready = !q_full && !busy_q[bank_q];
	assign accept   = rx.valid && rx.ready;

	always_comb begin
		pos_d  = pos_q;
		sum_d  = sum_q;
		chk_d  = chk_q;
		bank_d = bank_q;
		busy_d = busy_q;
		push   = '0;
		mem_wr = '0;
		if (rel.en)
			busy_d[rel.bank] = 1'b0;
		if (accept) begin
			if (rx.rx_byte == head_q) begin
				pos_d = POS_W'(1);
				sum_d = '0;
			end else if (pos_q == '0 || pos_q >= POS_W'(FRAME_LEN)) begin
				pos_d = '0;
			end else begin
				if (pos_q <= POS_W'(FRAME_LEN - 3)) begin
					sum_d       = sum_q + rx.rx_byte;
					mem_wr.en   = 1'b1;
					mem_wr.addr = (bank_q ? BANK1_BASE : '0) + ADDR_W'(pos_q - POS_W'(1));
					mem_wr.data = rx.rx_byte;
				end
				if (pos_q == POS_W'(FRAME_LEN - 2))
					chk_d = rx.rx_byte;
				if (pos_q != POS_W'(FRAME_LEN - 1)) begin
					// early tail drops the frame silently
					pos_d = (rx.rx_byte == tail_q) ? '0 : pos_q + POS_W'(1);
				end else begin
					pos_d          = '0;
					push.valid     = 1'b1;
					push.job.bank  = bank_q;
					if (rx.rx_byte != tail_q) begin
						push.job.op    = JOB_BAD_TAIL;
						push.job.value = rx.rx_byte;
					end else if (sum_q != chk_q) begin
						push.job.op    = JOB_BAD_SUM;
						push.job.value = sum_q;
					end else begin
						push.job.op    = JOB_DECODE;
						push.job.value = '0;
						busy_d[bank_q] = 1'b1;
						bank_d         = !bank_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= HEAD_RESET;
			tail_q <= TAIL_RESET;
			pos_q  <= '0;
			sum_q  <= '0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_HEAD: head_q <= cfg_data;
					REG_TAIL: tail_q <= cfg_data;
					default:  head_q <= head_q;
				endcase
			end
			pos_q  <= pos_d;
			sum_q  <= sum_d;
			bank_q <= bank_d;
			busy_q <= busy_d;
		end
	end

	always_ff @(posedge clk) begin
		chk_q <= chk_d;
	end

`ifndef ASSERT_OFF
	a_no_write_busy_bank: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.en |-> !busy_q[bank_q])
		else $error("frame byte written into a bank under decode");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !q_full)
		else $error("job issued into a full queue");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < POS_W'(FRAME_LEN))
		else $error("byte position beyond frame length");
`endif

endmodule

// File: hw/rtl/sfd_jobq.sv
// ----------------------------------------------------------------------------
// sfd_jobq
// Short FIFO of frame jobs between the byte front end and the decoder.
// ----------------------------------------------------------------------------
module sfd_jobq (
	input  logic               clk,
	input  logic               arst_n,
	input  sfd_pkg::job_push_t push,
	input  logic               pop,
	output logic               full,
	output logic               empty,
	output sfd_pkg::job_t      head
);
	import sfd_pkg::*;

	job_t                  slot_q [JOBQ_DEPTH];
	logic [JOBQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [JOBQ_CNT_W-1:0] cnt_q;
	logic                  do_push, do_pop;

	assign full    = cnt_q == JOBQ_CNT_W'(JOBQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push.valid && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + JOBQ_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + JOBQ_PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + JOBQ_CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - JOBQ_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push.job;
	end

endmodule

// File: hw/rtl/sfd_back.sv
// ----------------------------------------------------------------------------
// sfd_back
// Decoder: holds the two-bank frame store, walks a finished frame byte by
// byte, assembles little-endian fields and drives the result register.
// ----------------------------------------------------------------------------
module sfd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sfd_pkg::mem_wr_t   mem_wr,
	input  logic               q_empty,
	input  sfd_pkg::job_t      q_job,
	output logic               pop,
	output sfd_pkg::bank_rel_t rel,
	sfd_out_if.source          res
);
	import sfd_pkg::*;

	logic [BYTE_W-1:0]  mem [MEM_DEPTH];
	logic [BYTE_W-1:0]  rdata_q;

	back_state_t        state_q, state_d;
	kind_t              kind_q;
	logic [3:0]         idx_q;
	logic [1:0]         byte_q;
	logic [FCNT_W-1:0]  fcnt_q;
	logic               err_q;
	logic               bank_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [VALUE_W-1:0] value_q;

	logic               out_valid_q;
	kind_t              out_kind_q;
	logic [3:0]         out_idx_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_last_q;

	logic               slot_free, field_done, is_last, load;

	assign slot_free  = !out_valid_q || res.ready;
	assign field_done = (3'(byte_q) + 3'd1) == kind_bytes(kind_q);
	assign is_last    = fcnt_q == FCNT_W'(TOTAL_FIELDS - 1);

	always_ff @(posedge clk) begin
		if (mem_wr.en)
			mem[mem_wr.addr] <= mem_wr.data;
		rdata_q <= mem[addr_q];
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		rel     = '0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = (q_job.op == JOB_DECODE) ? B_READ : B_EMIT;
				end
			end
			B_READ: state_d = B_ACC;
			B_ACC:  state_d = field_done ? B_EMIT : B_READ;
			B_EMIT: begin
				if (slot_free) begin
					load = 1'b1;
					if (is_last) begin
						state_d  = B_IDLE;
						rel.en   = !err_q;
						rel.bank = bank_q;
					end else begin
						state_d = B_READ;
					end
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			idx_q   <= '0;
			byte_q  <= '0;
			bank_q  <= q_job.bank;
			addr_q  <= q_job.bank ? BANK1_BASE : '0;
			value_q <= VALUE_W'(q_job.value);
			unique case (q_job.op)
				JOB_DECODE: begin
					kind_q <= KIND_BOOL;
					fcnt_q <= '0;
					err_q  <= 1'b0;
				end
				JOB_BAD_SUM: begin
					kind_q <= KIND_BAD_SUM;
					fcnt_q <= FCNT_W'(TOTAL_FIELDS - 1);
					err_q  <= 1'b1;
				end
				default: begin
					kind_q <= KIND_BAD_TAIL;
					fcnt_q <= FCNT_W'(TOTAL_FIELDS - 1);
					err_q  <= 1'b1;
				end
			endcase
		end else if (state_q == B_ACC) begin
			if (byte_q == 2'd0)
				value_q <= VALUE_W'(rdata_q);
			else
				value_q[8*byte_q +: 8] <= rdata_q;
			if (!field_done) begin
				byte_q <= byte_q + 2'd1;
				addr_q <= addr_q + ADDR_W'(1);
			end
		end else if (load && !is_last) begin
			addr_q <= addr_q + ADDR_W'(1);
			byte_q <= '0;
			fcnt_q <= fcnt_q + FCNT_W'(1);
			if (idx_q + 4'd1 == kind_count(kind_q)) begin
				kind_q <= next_kind(kind_q);
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q  <= kind_q;
			out_idx_q   <= idx_q;
			out_value_q <= (kind_q == KIND_BOOL) ?
				(value_q & VALUE_W'(bool_mask(idx_q))) : value_q;
			out_last_q  <= is_last;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.field_kind  = out_kind_q;
	assign res.field_index = out_idx_q;
	assign res.field_value = out_value_q;
	assign res.last_field  = out_last_q;

`ifndef ASSERT_OFF
	a_idx_in_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != B_IDLE && !err_q) |-> (idx_q < kind_count(kind_q)))
		else $error("field index beyond its kind");

	a_addr_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ) |-> (addr_q < ADDR_W'(MEM_DEPTH)))
		else $error("store read beyond depth");

	a_release_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		rel.en |=> (state_q == B_IDLE && out_valid_q && res.last_field))
		else $error("bank released before the last field was loaded");
`endif

endmodule

// File: hw/rtl/serial_frame_deframer_checksum.sv
// ----------------------------------------------------------------------------
// serial_frame_deframer_checksum
// Head/tail framed packet receiver with an 8-bit sum check and field decode.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries received bytes, one per transaction; the byte path takes one
//   byte per cycle while rx.ready is high. res carries decoded fields in
//   layout order, one per transaction, last_field set on the final one of a
//   frame. A bad final tail or sum gives one bad-tail or bad-checksum result.
//   Registers (cfg_wen/cfg_index/cfg_data): head byte and tail byte; write
//   only while the block is idle.
//   An error result passes from the job queue through the decoder's EMIT
//   state into the result register. A good frame is read from the frame
//   store byte by byte (states READ then ACC per byte, EMIT per field).
//   The store has two banks, so one frame can be received while the previous
//   one is decoded; rx.ready drops if a third frame would need a bank still
//   in use or the job queue is full.
//   A stalled res holds its result and backs up the decoder, then rx.
//   Reset: no frame open, head 0xA5, tail 0x5A, queue and output empty.
// ----------------------------------------------------------------------------
module serial_frame_deframer_checksum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  sfd_pkg::reg_idx_t cfg_index,
	input  logic [7:0]        cfg_data,
	sfd_in_if.sink            rx,
	sfd_out_if.source         res
);
	import sfd_pkg::*;

	job_push_t push;
	mem_wr_t   mem_wr;
	bank_rel_t rel;
	job_t      q_job;
	logic      q_full, q_empty, pop;

	sfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx),
		.q_full    (q_full),
		.rel       (rel),
		.push      (push),
		.mem_wr    (mem_wr)
	);

	sfd_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.empty  (q_empty),
		.head   (q_job)
	);

	sfd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_wr  (mem_wr),
		.q_empty (q_empty),
		.q_job   (q_job),
		.pop     (pop),
		.rel     (rel),
		.res     (res)
	);

endmodule
